// ----- hw/rtl/rpd_pkg.sv -----
package rpd_pkg;

	// size limit of one receive buffer, before the buffer_bytes register is applied
	localparam int unsigned BUF_BYTES = 16384;
	localparam int unsigned COUNT_CAP = 16384;
	localparam int unsigned SIZE_CAP  = (BUF_BYTES < COUNT_CAP) ? BUF_BYTES : COUNT_CAP;
	localparam int unsigned CNT_W     = 15;
	localparam int unsigned SLOT_W    = 9;
	localparam int unsigned SLOT_LSB  = 5;

	localparam logic [CNT_W-1:0] SIZE_CAP_W         = CNT_W'(SIZE_CAP);
	localparam logic [CNT_W-1:0] SLOT_BYTES         = CNT_W'(32);
	localparam logic [CNT_W-1:0] BUFFER_BYTES_RESET = CNT_W'(10240);

	localparam logic [63:0] START_MARK = 64'h5566778811223344;
	localparam logic [63:0] END_MARK   = 64'h4433221188776655;
	localparam logic [15:0] CMD_STORE  = 16'd1;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_TAKE,
		KIND_START,
		KIND_END,
		KIND_DATA
	} rpd_kind_t;

	typedef enum logic [3:0] {
		EV_IGNORED  = 4'd0,
		EV_STARTED  = 4'd1,
		EV_STORED   = 4'd2,
		EV_DROPPED  = 4'd3,
		EV_COMPLETE = 4'd4,
		EV_LOST     = 4'd5,
		EV_NOBUF    = 4'd6,
		EV_TAKEN    = 4'd7,
		EV_NONE     = 4'd8
	} rpd_event_t;

	typedef enum logic {
		CFG_BUFFERS_READY = 1'b0,
		CFG_BUFFER_BYTES  = 1'b1
	} rpd_cfg_reg_t;

	typedef struct packed {
		rpd_kind_t   kind;
		logic [15:0] cmd;
		logic [31:0] len;
		logic [63:0] w0;
		logic [63:0] w1;
		logic [63:0] w2;
		logic [63:0] w3;
	} rpd_item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} rpd_q_status_t;

	typedef struct packed {
		logic             buffers_ready;
		logic [CNT_W-1:0] buffer_bytes;
	} rpd_cfg_t;

endpackage

// ----- hw/rtl/rpd_front.sv -----
module rpd_front import rpd_pkg::*; (
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          mode,
	input  logic [63:0]   payload_word0,
	input  logic [63:0]   payload_word1,
	input  logic [63:0]   payload_word2,
	input  logic [63:0]   payload_word3,
	input  rpd_q_status_t q_status,
	output logic          push,
	output rpd_item_t     item
);

	assign in_stall = q_status.full;
	assign push     = in_valid && !q_status.full;

	always_comb begin
		item.w0 = payload_word0;
		item.w1 = payload_word1;
		item.w2 = payload_word2;
		item.w3 = payload_word3;
		// command id is byte 8 high, byte 9 low; length is bytes 10..13
		item.cmd = {payload_word1[7:0], payload_word1[15:8]};
		item.len = payload_word1[47:16];
		if (mode) begin
			item.kind = KIND_TAKE;
		end else if (payload_word0 == START_MARK) begin
			item.kind = KIND_START;
		end else if (payload_word0 == END_MARK) begin
			item.kind = KIND_END;
		end else begin
			item.kind = KIND_DATA;
		end
	end

endmodule

// ----- hw/rtl/rpd_queue.sv -----
module rpd_queue import rpd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rpd_item_t     push_item,
	input  logic          pop,
	output rpd_item_t     head_item,
	output rpd_q_status_t status
);

	rpd_item_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_item    = entry_q[rd_ptr_q];
	assign do_pop       = pop && !status.empty;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/rpd_back.sv -----
module rpd_back import rpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  rpd_cfg_t          cfg,
	input  rpd_q_status_t     q_status,
	input  rpd_item_t         head_item,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [3:0]        event_res,
	output logic              write_enable,
	output logic              write_buffer,
	output logic [SLOT_W-1:0] write_slot,
	output logic [63:0]       data_word0,
	output logic [63:0]       data_word1,
	output logic [63:0]       data_word2,
	output logic [63:0]       data_word3,
	output logic [1:0]        take_buffer,
	output logic [CNT_W-1:0]  take_length
);

	// deframer state
	logic             active_buffer_q, active_buffer_n;
	logic             active_valid_q, active_valid_n;
	logic [15:0]      command_id_q, command_id_n;
	logic [31:0]      expected_length_q, expected_length_n;
	logic [1:0]       buffer_full_q, buffer_full_n;
	logic [CNT_W-1:0] rb_q [2];
	logic [CNT_W-1:0] rb_n [2];
	logic             newest_buffer_q, newest_buffer_n;

	// result register
	logic             out_valid_q;
	rpd_event_t       ev_q, ev_n;
	logic             wen_q, wen_n;
	logic             wbuf_q, wbuf_n;
	logic [SLOT_W-1:0] slot_q, slot_n;
	logic [63:0]      d0_q, d1_q, d2_q, d3_q;
	logic [63:0]      d0_n, d1_n, d2_n, d3_n;
	logic [1:0]       tbuf_q, tbuf_n;
	logic [CNT_W-1:0] tlen_q, tlen_n;

	logic             fire;
	logic             pick;
	logic             cur;
	logic [CNT_W-1:0] cnt;
	logic [CNT_W-1:0] limit;

	assign pop  = !out_valid_q || !out_stall;
	assign fire = pop && !q_status.empty;

	assign limit = (cfg.buffer_bytes < SIZE_CAP_W) ? cfg.buffer_bytes : SIZE_CAP_W;
	assign cur   = active_buffer_q;
	assign cnt   = rb_q[active_buffer_q];

	always_comb begin
		active_buffer_n   = active_buffer_q;
		active_valid_n    = active_valid_q;
		command_id_n      = command_id_q;
		expected_length_n = expected_length_q;
		buffer_full_n     = buffer_full_q;
		rb_n[0]           = rb_q[0];
		rb_n[1]           = rb_q[1];
		newest_buffer_n   = newest_buffer_q;
		ev_n   = EV_IGNORED;
		wen_n  = 1'b0;
		wbuf_n = 1'b0;
		slot_n = '0;
		d0_n   = '0;
		d1_n   = '0;
		d2_n   = '0;
		d3_n   = '0;
		tbuf_n = '0;
		tlen_n = '0;
		pick   = 1'b0;
		case (head_item.kind)
			KIND_TAKE: begin
				if (buffer_full_q[0] && buffer_full_q[1]) begin
					pick = newest_buffer_q;
				end else if (buffer_full_q[0]) begin
					pick = 1'b0;
				end else begin
					pick = 1'b1;
				end
				if (buffer_full_q != 2'b00) begin
					ev_n   = EV_TAKEN;
					tbuf_n = {pick, ~pick};
					tlen_n = rb_q[pick];
					buffer_full_n[pick] = 1'b0;
				end else begin
					ev_n = EV_NONE;
				end
			end
			KIND_START: begin
				if (!cfg.buffers_ready) begin
					active_valid_n = 1'b0;
					ev_n           = EV_NOBUF;
				end else begin
					if (!buffer_full_q[0]) begin
						pick = 1'b0;
					end else if (!buffer_full_q[1]) begin
						pick = 1'b1;
					end else begin
						pick = ~newest_buffer_q;
					end
					active_buffer_n     = pick;
					active_valid_n      = 1'b1;
					buffer_full_n[pick] = 1'b0;
					rb_n[pick]          = '0;
					command_id_n        = head_item.cmd;
					expected_length_n   = head_item.len;
					ev_n                = EV_STARTED;
				end
			end
			KIND_END, KIND_DATA: begin
				if (command_id_q != CMD_STORE) begin
					ev_n = EV_IGNORED;
				end else if (!active_valid_q) begin
					ev_n = EV_NOBUF;
				end else if (head_item.kind == KIND_END) begin
					if ({{(32 - CNT_W){1'b0}}, cnt} == expected_length_q) begin
						buffer_full_n[cur] = 1'b1;
						newest_buffer_n    = cur;
						ev_n               = EV_COMPLETE;
					end else begin
						rb_n[cur] = '0;
						ev_n      = EV_LOST;
					end
				end else if (({{(32 - CNT_W){1'b0}}, cnt} < expected_length_q) &&
						(cnt < limit)) begin
					ev_n      = EV_STORED;
					wen_n     = 1'b1;
					wbuf_n    = cur;
					// slot index is the count in 32-byte units
					slot_n    = cnt[SLOT_LSB +: SLOT_W];
					d0_n      = head_item.w0;
					d1_n      = head_item.w1;
					d2_n      = head_item.w2;
					d3_n      = head_item.w3;
					rb_n[cur] = cnt + SLOT_BYTES;
				end else begin
					ev_n = EV_DROPPED;
				end
			end
			default: begin
				ev_n = EV_IGNORED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_buffer_q   <= 1'b0;
			active_valid_q    <= 1'b0;
			command_id_q      <= '0;
			expected_length_q <= '0;
			buffer_full_q     <= '0;
			rb_q[0]           <= '0;
			rb_q[1]           <= '0;
			newest_buffer_q   <= 1'b0;
			out_valid_q       <= 1'b0;
		end else begin
			if (fire) begin
				active_buffer_q   <= active_buffer_n;
				active_valid_q    <= active_valid_n;
				command_id_q      <= command_id_n;
				expected_length_q <= expected_length_n;
				buffer_full_q     <= buffer_full_n;
				rb_q[0]           <= rb_n[0];
				rb_q[1]           <= rb_n[1];
				newest_buffer_q   <= newest_buffer_n;
				out_valid_q       <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ev_q   <= ev_n;
			wen_q  <= wen_n;
			wbuf_q <= wbuf_n;
			slot_q <= slot_n;
			d0_q   <= d0_n;
			d1_q   <= d1_n;
			d2_q   <= d2_n;
			d3_q   <= d3_n;
			tbuf_q <= tbuf_n;
			tlen_q <= tlen_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = ev_q;
	assign write_enable = wen_q;
	assign write_buffer = wbuf_q;
	assign write_slot   = slot_q;
	assign data_word0   = d0_q;
	assign data_word1   = d1_q;
	assign data_word2   = d2_q;
	assign data_word3   = d3_q;
	assign take_buffer  = tbuf_q;
	assign take_length  = tlen_q;

endmodule

// ----- hw/rtl/radio_packet_deframer_double_buffer.sv -----
// Radio payload deframer with two receive buffers. Each item is a 32-byte radio
// payload (mode 0) or a host take request (mode 1) and gives exactly one result
// item. Sustained rate is one item per clock while out_stall is low: the back end
// updates the buffer state for each item as it registers that item's result,
// and that update is what sets the rate. An accepted item passes through the
// classifier into a two-entry queue and from the queue head into the result
// register; the queue lets input keep flowing for two items while the output is
// stalled. Configuration (buffers_ready at index 0, buffer_bytes at index 1)
// should only be written while no item is in flight.
module radio_packet_deframer_double_buffer import rpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic              cfg_index,
	input  logic [CNT_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	input  logic [63:0]       payload_word0,
	input  logic [63:0]       payload_word1,
	input  logic [63:0]       payload_word2,
	input  logic [63:0]       payload_word3,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [3:0]        event_res,
	output logic              write_enable,
	output logic              write_buffer,
	output logic [SLOT_W-1:0] write_slot,
	output logic [63:0]       data_word0,
	output logic [63:0]       data_word1,
	output logic [63:0]       data_word2,
	output logic [63:0]       data_word3,
	output logic [1:0]        take_buffer,
	output logic [CNT_W-1:0]  take_length
);

	rpd_cfg_t      cfg_q;
	rpd_q_status_t q_status;
	rpd_item_t     front_item;
	rpd_item_t     head_item;
	logic          push;
	logic          pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buffers_ready <= 1'b0;
			cfg_q.buffer_bytes  <= BUFFER_BYTES_RESET;
		end else if (cfg_write) begin
			case (rpd_cfg_reg_t'(cfg_index))
				CFG_BUFFERS_READY: cfg_q.buffers_ready <= cfg_data[0];
				CFG_BUFFER_BYTES:  cfg_q.buffer_bytes  <= cfg_data;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	rpd_front u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.payload_word0 (payload_word0),
		.payload_word1 (payload_word1),
		.payload_word2 (payload_word2),
		.payload_word3 (payload_word3),
		.q_status      (q_status),
		.push          (push),
		.item          (front_item)
	);

	rpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (pop),
		.head_item (head_item),
		.status    (q_status)
	);

	rpd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_status     (q_status),
		.head_item    (head_item),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_res    (event_res),
		.write_enable (write_enable),
		.write_buffer (write_buffer),
		.write_slot   (write_slot),
		.data_word0   (data_word0),
		.data_word1   (data_word1),
		.data_word2   (data_word2),
		.data_word3   (data_word3),
		.take_buffer  (take_buffer),
		.take_length  (take_length)
	);

	// a store write goes out only with the stored event
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (write_enable == (event_res == EV_STORED)))
		else $error("write_enable does not match stored event");

	// a buffer is named on take only for the taken event, and never both buffers
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (((take_buffer != 2'b00) == (event_res == EV_TAKEN)) &&
			(take_buffer != 2'b11)))
		else $error("take_buffer inconsistent with event");

	// queue cannot be full and empty, and a full queue must hold off the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty) && !(q_status.full && push))
		else $error("queue status inconsistent");

endmodule
